// ----- rtl/assert_macros.svh -----
// Assertion macros used by the freeze looper RTL.
// Depends on nothing; compiled to empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/fflc_pkg.sv -----
// Shared types and constants of the freeze looper: item structs, sequencer states,
// register indexes and the divider request/response bundles. Depends on nothing.
package fflc_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int FADE_MAX_DEF    = 4096;

    localparam int AMT_W      = 17;
    localparam int LEN_CFG_W  = 17;
    localparam int FADE_W     = 13;
    localparam int STEPS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [AMT_W-1:0]     AMOUNT_ONE     = 17'd65536;
    localparam logic [LEN_CFG_W-1:0] LOOP_LEN_RESET = 17'd32768;
    localparam logic [FADE_W-1:0]    XFADE_RESET    = 13'd480;
    localparam logic [STEPS_W-1:0]   STEPS_RESET    = 16'd2400;

    // divider: magnitude of a sample times a fade weight, or of a ramp delta << 15
    localparam int DIV_W = SAMPLE_BITS + FADE_W + 1;
    localparam int DEN_W = 16;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] wet_left;
        logic signed [SAMPLE_BITS-1:0] wet_right;
        logic [AMT_W-1:0]              freeze_target;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } out_item_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_LEN   = 2'd0,
        REG_XFADE      = 2'd1,
        REG_RAMP_STEPS = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TGT,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_RAMP,
        ST_RAMP_MUL,
        ST_EDGE,
        ST_CAP,
        ST_PLAY,
        ST_PLAY_K,
        ST_PLAY_B,
        ST_LDIV_GO,
        ST_LDIV_WAIT,
        ST_XDIV_GO,
        ST_XDIV_WAIT,
        ST_MIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic             rem_nz;
    } div_rsp_t;

endpackage

// ----- rtl/fflc_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module fflc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fflc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fflc_pkg for the request/response bundles.
module fflc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fflc_pkg::div_req_t req,
    output fflc_pkg::div_rsp_t rsp
);
    import fflc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_step;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_step = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.num;
                den_reg  <= req.den;
            end else if (busy_reg) begin
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;
    assign rsp.rem_nz = rem_reg != '0;

endmodule

// ----- rtl/freeze_loop_capture_crossfade.sv -----
// Freeze looper with capture and crossfade: top level, sequencer and datapath.
// Depends on fflc_pkg, fflc_ram, fflc_div and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_data  (in_item_t)
//   m_      | out       | m_valid / m_ready  | m_data  (out_item_t)
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time. While a ramp runs an item can also pass the ramp multiply
// state; inside the fade zone a blend step and two crossfade divides are added.
// A new target adds one ramp divide unless the ramp step count is zero. The
// divider yields one quotient bit per cycle. A capture reads one history entry
// and writes one loop entry per cycle.
// Reset is synchronous; the memories need no clearing pass, a history fill count
// stands in for the zeroed history. The output register lets the next item in
// while a result waits on m_ready. Configuration is taken only while idle.
`include "assert_macros.svh"

module freeze_loop_capture_crossfade #(
    parameter int STORE_DEPTH = fflc_pkg::STORE_DEPTH_DEF,
    parameter int FADE_MAX    = fflc_pkg::FADE_MAX_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fflc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fflc_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fflc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fflc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fflc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = $clog2(STORE_DEPTH);
    localparam int LW    = $clog2(STORE_DEPTH + 1);
    localparam int CW    = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
    localparam int FW2   = (LW > FADE_W) ? LW : FADE_W;
    localparam int NUMW  = DIV_W + 1;
    localparam int PRODW = SB + FADE_W + 1;
    localparam int MPW   = SB + AMT_W + 1;
    localparam int MIXW  = MPW + 1;
    localparam logic [FADE_W-1:0] FADE_CAP =
        (FADE_MAX > 8191) ? 13'h1FFF : 13'(FADE_MAX);
    localparam logic signed [MIXW-1:0] SMAX = {{(MIXW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [MIXW-1:0] SMIN = ~SMAX;

    // ---------------- registers ----------------
    state_t state_reg, state_next;

    logic [LEN_CFG_W-1:0] loop_len_cfg_reg;
    logic [FADE_W-1:0]    xfade_cfg_reg;
    logic [STEPS_W-1:0]   steps_cfg_reg;

    in_item_t item_reg, item_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [LW-1:0] hcnt_reg, hcnt_next;           // history entries written since reset

    logic [LW-1:0]     act_len_reg, act_len_next;
    logic [FADE_W-1:0] act_fade_reg, act_fade_next;
    logic [PW-1:0]     pos_reg, pos_next;

    logic [AMT_W-1:0]   amt_now_reg, amt_now_next;
    logic [AMT_W-1:0]   amt_before_reg, amt_before_next;
    logic [AMT_W-1:0]   amt_goal_reg, amt_goal_next;
    logic [STEPS_W-1:0] ramp_left_reg, ramp_left_next;
    logic signed [31:0] ramp_inc_reg, ramp_inc_next;
    logic               ramp_neg_reg, ramp_neg_next;
    logic signed [48:0] ramp_prod_reg, ramp_prod_next;

    logic [LW-1:0] cap_i_reg, cap_i_next;
    logic [PW-1:0] cap_src_reg, cap_src_next;
    logic          cap_rd_vld_reg, cap_rd_vld_next;
    logic [PW-1:0] cap_wr_idx_reg, cap_wr_idx_next;
    logic          cap_keep_reg, cap_keep_next;

    logic                   in_fade_reg, in_fade_next;
    logic [PW-1:0]          k_reg, k_next;
    logic [2*SB-1:0]        a_reg, a_next;
    logic signed [NUMW-1:0] num_l_reg, num_l_next;
    logic signed [NUMW-1:0] num_r_reg, num_r_next;
    logic signed [SB-1:0]   wet_l_reg, wet_l_next;
    logic signed [SB-1:0]   wet_r_reg, wet_r_next;
    logic signed [MIXW-1:0] mix_l_reg, mix_l_next;
    logic signed [MIXW-1:0] mix_r_reg, mix_r_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // ---------------- memories and divider ----------------
    logic            accept;
    logic [2*SB-1:0] hist_q;
    logic [2*SB-1:0] loop_q;
    logic [PW-1:0]   loop_raddr;
    div_req_t        div_req;
    div_rsp_t        div_rsp;

    assign s_ready   = state_reg == ST_IDLE;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // History and loop stores can see a read and a write of the same entry at once,
    // but the sequencer orders every access so that such read data is never used.
    fflc_ram #(.DEPTH(STORE_DEPTH), .WIDTH(2*SB)) u_hist (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata ({s_data.wet_left, s_data.wet_right}),
        .raddr (cap_src_reg),
        .rdata (hist_q)
    );

    // never-written history entries (fill count) copy in as zero
    fflc_ram #(.DEPTH(STORE_DEPTH), .WIDTH(2*SB)) u_loop (
        .aclk  (aclk),
        .we    (cap_rd_vld_reg),
        .waddr (cap_wr_idx_reg),
        .wdata (cap_keep_reg ? hist_q : '0),
        .raddr (loop_raddr),
        .rdata (loop_q)
    );

    fflc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- freeze amount ramp ----------------
    logic [AMT_W-1:0]   tgt_sat;
    logic               tgt_neg;
    logic [AMT_W-1:0]   tgt_mag;
    logic [DIV_W-1:0]   ramp_num;
    logic [STEPS_W-1:0] rl_dec;
    logic signed [48:0] ramp_mul;
    logic signed [48:0] ramp_rd;
    logic signed [49:0] ramp_v;
    logic [AMT_W-1:0]   ramp_clamped;
    logic signed [31:0] ramp_inc_div;

    assign tgt_sat  = (item_reg.freeze_target > AMOUNT_ONE) ? AMOUNT_ONE
                                                            : item_reg.freeze_target;
    assign tgt_neg  = tgt_sat < amt_now_reg;
    assign tgt_mag  = tgt_neg ? amt_now_reg - tgt_sat : tgt_sat - amt_now_reg;
    assign ramp_num = DIV_W'({tgt_mag, 15'd0});
    assign rl_dec   = ramp_left_reg - 16'd1;
    assign ramp_mul = $signed({1'b0, rl_dec}) * ramp_inc_reg;
    assign ramp_rd  = (ramp_prod_reg + 49'sd16384) >>> 15;
    assign ramp_v   = $signed({33'b0, amt_goal_reg}) - 50'(ramp_rd);
    assign ramp_clamped = ramp_v[49] ? '0 :
                          (ramp_v > 50'sd65536) ? AMOUNT_ONE : 17'(ramp_v);
    // truncated quotient, saturated to 32 bits (step count of one only)
    assign ramp_inc_div = ramp_neg_reg ? -(32'(div_rsp.quo)) :
                          (div_rsp.quo > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                               : 32'(div_rsp.quo);

    // ---------------- capture setup ----------------
    logic [CW-1:0]     cfg_len_ext;
    logic [LW-1:0]     cap_len;
    logic [FADE_W-1:0] fade_lim;
    logic [LW-1:0]     cap_half;
    logic [FADE_W-1:0] cap_fade;
    logic [LW-1:0]     wp_l;
    logic [PW-1:0]     cap_base;
    logic [LW-1:0]     cap_age;
    logic [PW-1:0]     src_inc;
    logic [PW-1:0]     wp_inc;

    assign cfg_len_ext = CW'(loop_len_cfg_reg);
    assign cap_len  = (cfg_len_ext == '0) ? LW'(1) :
                      (cfg_len_ext > CW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : LW'(cfg_len_ext);
    assign fade_lim = (xfade_cfg_reg > FADE_CAP) ? FADE_CAP : xfade_cfg_reg;
    assign cap_half = cap_len >> 1;
    assign cap_fade = (FW2'(fade_lim) > FW2'(cap_half)) ? 13'(cap_half) : fade_lim;
    assign wp_l     = LW'(wp_reg);
    // oldest copied entry: write pointer minus length, modulo depth
    assign cap_base = (wp_l >= cap_len) ? PW'(wp_l - cap_len)
                                        : PW'(wp_l + LW'(STORE_DEPTH) - cap_len);
    assign cap_age  = act_len_reg - cap_i_reg;
    assign src_inc  = (cap_src_reg == PW'(STORE_DEPTH - 1)) ? '0 : cap_src_reg + PW'(1);
    assign wp_inc   = (wp_reg == PW'(STORE_DEPTH - 1)) ? '0 : wp_reg + PW'(1);

    // ---------------- playback and crossfade ----------------
    logic [LW-1:0] pos_l, fade_l, pos_fix_l, fade_start, pos_adv_l;
    logic          in_fade_now;
    logic [PW-1:0] k_now, pos_after;

    assign pos_l       = LW'(pos_reg);
    assign fade_l      = LW'(act_fade_reg);
    assign pos_fix_l   = (pos_l >= act_len_reg) ? fade_l : pos_l;
    assign fade_start  = act_len_reg - fade_l;
    assign in_fade_now = (act_fade_reg != '0) && (pos_fix_l >= fade_start);
    assign k_now       = PW'(pos_fix_l - fade_start);
    assign pos_adv_l   = pos_fix_l + LW'(1);
    // wrap to the crossfade point, not to zero
    assign pos_after   = (pos_adv_l >= act_len_reg) ? PW'(fade_l) : PW'(pos_adv_l);

    logic [FADE_W-1:0]        kk;
    logic signed [FADE_W:0]   wk_s, k_s, half_s;
    logic signed [SB-1:0]     a_l, a_r, b_l, b_r;
    logic signed [PRODW-1:0]  pa_l, pa_r, pb_l, pb_r;
    logic signed [NUMW-1:0]   blend_l, blend_r;
    logic [DIV_W-1:0]         num_l_mag, num_r_mag;
    logic [DIV_W-1:0]         q_adj;
    logic signed [SB-1:0]     div_floor_l, div_floor_r;

    assign kk     = 13'(k_reg);
    assign wk_s   = $signed({1'b0, act_fade_reg - kk});
    assign k_s    = $signed({1'b0, kk});
    assign half_s = $signed({1'b0, act_fade_reg >> 1});
    assign a_l    = a_reg[2*SB-1:SB];
    assign a_r    = a_reg[SB-1:0];
    assign b_l    = loop_q[2*SB-1:SB];
    assign b_r    = loop_q[SB-1:0];
    assign pa_l   = a_l * wk_s;
    assign pa_r   = a_r * wk_s;
    assign pb_l   = b_l * k_s;
    assign pb_r   = b_r * k_s;
    // numerator biased by half the divisor, divided with floor below
    assign blend_l = NUMW'(pa_l) + NUMW'(pb_l) + NUMW'(half_s);
    assign blend_r = NUMW'(pa_r) + NUMW'(pb_r) + NUMW'(half_s);

    assign num_l_mag = num_l_reg[NUMW-1] ? DIV_W'(-num_l_reg) : DIV_W'(num_l_reg);
    assign num_r_mag = num_r_reg[NUMW-1] ? DIV_W'(-num_r_reg) : DIV_W'(num_r_reg);
    assign q_adj     = div_rsp.quo + DIV_W'(div_rsp.rem_nz);
    assign div_floor_l = num_l_reg[NUMW-1] ? SB'(-q_adj) : SB'(div_rsp.quo);
    assign div_floor_r = num_r_reg[NUMW-1] ? SB'(-q_adj) : SB'(div_rsp.quo);

    // ---------------- dry/loop mix ----------------
    logic [AMT_W-1:0]       amt_inv;
    logic signed [MPW-1:0]  md_l, md_r, mw_l, mw_r;
    logic signed [MIXW-1:0] mix_rnd_l, mix_rnd_r;
    logic signed [SB-1:0]   sat_l, sat_r;

    assign amt_inv = AMOUNT_ONE - amt_now_reg;
    assign md_l = item_reg.wet_left * $signed({1'b0, amt_inv});
    assign md_r = item_reg.wet_right * $signed({1'b0, amt_inv});
    assign mw_l = wet_l_reg * $signed({1'b0, amt_now_reg});
    assign mw_r = wet_r_reg * $signed({1'b0, amt_now_reg});
    assign mix_rnd_l = (mix_l_reg + MIXW'(32768)) >>> 16;
    assign mix_rnd_r = (mix_r_reg + MIXW'(32768)) >>> 16;
    assign sat_l = (mix_rnd_l > SMAX) ? SB'(SMAX) :
                   (mix_rnd_l < SMIN) ? SB'(SMIN) : SB'(mix_rnd_l);
    assign sat_r = (mix_rnd_r > SMAX) ? SB'(SMAX) :
                   (mix_rnd_r < SMIN) ? SB'(SMIN) : SB'(mix_rnd_r);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        wp_next         = wp_reg;
        hcnt_next       = hcnt_reg;
        act_len_next    = act_len_reg;
        act_fade_next   = act_fade_reg;
        pos_next        = pos_reg;
        amt_now_next    = amt_now_reg;
        amt_before_next = amt_before_reg;
        amt_goal_next   = amt_goal_reg;
        ramp_left_next  = ramp_left_reg;
        ramp_inc_next   = ramp_inc_reg;
        ramp_neg_next   = ramp_neg_reg;
        ramp_prod_next  = ramp_prod_reg;
        cap_i_next      = cap_i_reg;
        cap_src_next    = cap_src_reg;
        cap_rd_vld_next = 1'b0;
        cap_wr_idx_next = cap_wr_idx_reg;
        cap_keep_next   = cap_keep_reg;
        in_fade_next    = in_fade_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        num_l_next      = num_l_reg;
        num_r_next      = num_r_reg;
        wet_l_next      = wet_l_reg;
        wet_r_next      = wet_r_reg;
        mix_l_next      = mix_l_reg;
        mix_r_next      = mix_r_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        loop_raddr      = pos_reg;
        div_req         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next  = s_data;
                    wp_next    = wp_inc;
                    hcnt_next  = (hcnt_reg == LW'(STORE_DEPTH)) ? hcnt_reg
                                                                : hcnt_reg + LW'(1);
                    state_next = ST_TGT;
                end
            end
            ST_TGT: begin
                if (tgt_sat == amt_goal_reg) begin
                    state_next = ST_RAMP;
                end else if (steps_cfg_reg == '0) begin
                    amt_goal_next  = tgt_sat;
                    amt_now_next   = tgt_sat;
                    ramp_left_next = '0;
                    ramp_inc_next  = '0;
                    state_next     = ST_RAMP;
                end else begin
                    amt_goal_next  = tgt_sat;
                    ramp_left_next = steps_cfg_reg;
                    ramp_neg_next  = tgt_neg;
                    state_next     = ST_RDIV_GO;
                end
            end
            ST_RDIV_GO: begin
                div_req.start = 1'b1;
                div_req.num   = ramp_num;
                div_req.den   = steps_cfg_reg;
                state_next    = ST_RDIV_WAIT;
            end
            ST_RDIV_WAIT: begin
                if (div_rsp.done) begin
                    ramp_inc_next = ramp_inc_div;
                    state_next    = ST_RAMP;
                end
            end
            ST_RAMP: begin
                if (ramp_left_reg == '0) begin
                    state_next = ST_EDGE;
                end else begin
                    ramp_left_next = rl_dec;
                    if (rl_dec == '0) begin
                        amt_now_next = amt_goal_reg;
                        state_next   = ST_EDGE;
                    end else begin
                        ramp_prod_next = ramp_mul;
                        state_next     = ST_RAMP_MUL;
                    end
                end
            end
            ST_RAMP_MUL: begin
                amt_now_next = ramp_clamped;
                state_next   = ST_EDGE;
            end
            ST_EDGE: begin
                amt_before_next = amt_now_reg;
                if (amt_before_reg == '0 && amt_now_reg != '0) begin
                    act_len_next  = cap_len;
                    act_fade_next = cap_fade;
                    cap_i_next    = '0;
                    cap_src_next  = cap_base;
                    pos_next      = '0;
                    state_next    = ST_CAP;
                end else begin
                    state_next = ST_PLAY;
                end
            end
            ST_CAP: begin
                // read history now, write the loop entry in the next cycle
                if (cap_i_reg < act_len_reg) begin
                    cap_rd_vld_next = 1'b1;
                    cap_wr_idx_next = PW'(cap_i_reg);
                    cap_keep_next   = cap_age <= hcnt_reg;
                    cap_i_next      = cap_i_reg + LW'(1);
                    cap_src_next    = src_inc;
                end else if (!cap_rd_vld_reg) begin
                    state_next = ST_PLAY;
                end
            end
            ST_PLAY: begin
                if (act_len_reg == '0) begin
                    wet_l_next = '0;
                    wet_r_next = '0;
                    state_next = ST_MIX;
                end else begin
                    loop_raddr   = PW'(pos_fix_l);
                    in_fade_next = in_fade_now;
                    k_next       = k_now;
                    pos_next     = pos_after;
                    state_next   = ST_PLAY_K;
                end
            end
            ST_PLAY_K: begin
                a_next     = loop_q;
                loop_raddr = k_reg;
                if (in_fade_reg) begin
                    state_next = ST_PLAY_B;
                end else begin
                    wet_l_next = loop_q[2*SB-1:SB];
                    wet_r_next = loop_q[SB-1:0];
                    state_next = ST_MIX;
                end
            end
            ST_PLAY_B: begin
                num_l_next = blend_l;
                num_r_next = blend_r;
                state_next = ST_LDIV_GO;
            end
            ST_LDIV_GO: begin
                div_req.start = 1'b1;
                div_req.num   = num_l_mag;
                div_req.den   = DEN_W'(act_fade_reg);
                state_next    = ST_LDIV_WAIT;
            end
            ST_LDIV_WAIT: begin
                if (div_rsp.done) begin
                    wet_l_next = div_floor_l;
                    state_next = ST_XDIV_GO;
                end
            end
            ST_XDIV_GO: begin
                div_req.start = 1'b1;
                div_req.num   = num_r_mag;
                div_req.den   = DEN_W'(act_fade_reg);
                state_next    = ST_XDIV_WAIT;
            end
            ST_XDIV_WAIT: begin
                if (div_rsp.done) begin
                    wet_r_next = div_floor_r;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                mix_l_next = MIXW'(md_l) + MIXW'(mw_l);
                mix_r_next = MIXW'(md_r) + MIXW'(mw_r);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_left  = sat_l;
                    m_data_next.out_right = sat_r;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers, written only while idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_len_cfg_reg <= LOOP_LEN_RESET;
            xfade_cfg_reg    <= XFADE_RESET;
            steps_cfg_reg    <= STEPS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOOP_LEN:   loop_len_cfg_reg <= cfg_data;
                REG_XFADE:      xfade_cfg_reg    <= cfg_data[FADE_W-1:0];
                REG_RAMP_STEPS: steps_cfg_reg    <= cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // looper state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            hcnt_reg       <= '0;
            act_len_reg    <= '0;
            act_fade_reg   <= '0;
            pos_reg        <= '0;
            amt_now_reg    <= '0;
            amt_before_reg <= '0;
            amt_goal_reg   <= '0;
            ramp_left_reg  <= '0;
            ramp_inc_reg   <= '0;
            cap_i_reg      <= '0;
            cap_rd_vld_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            wp_reg         <= wp_next;
            hcnt_reg       <= hcnt_next;
            act_len_reg    <= act_len_next;
            act_fade_reg   <= act_fade_next;
            pos_reg        <= pos_next;
            amt_now_reg    <= amt_now_next;
            amt_before_reg <= amt_before_next;
            amt_goal_reg   <= amt_goal_next;
            ramp_left_reg  <= ramp_left_next;
            ramp_inc_reg   <= ramp_inc_next;
            cap_i_reg      <= cap_i_next;
            cap_rd_vld_reg <= cap_rd_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        ramp_neg_reg   <= ramp_neg_next;
        ramp_prod_reg  <= ramp_prod_next;
        cap_src_reg    <= cap_src_next;
        cap_wr_idx_reg <= cap_wr_idx_next;
        cap_keep_reg   <= cap_keep_next;
        in_fade_reg    <= in_fade_next;
        k_reg          <= k_next;
        a_reg          <= a_next;
        num_l_reg      <= num_l_next;
        num_r_reg      <= num_r_next;
        wet_l_reg      <= wet_l_next;
        wet_r_reg      <= wet_r_next;
        mix_l_reg      <= mix_l_next;
        mix_r_reg      <= mix_r_next;
        m_data_reg     <= m_data_next;
    end

    // ---------------- checks ----------------
    `ASSERT_IMP(a_cap_bound, aclk, aresetn, state_reg == ST_CAP, cap_i_reg <= act_len_reg)
    `ASSERT_IMP(a_div_free, aclk, aresetn, div_req.start, !div_rsp.busy)
    `ASSERT_IMP(a_amt_range, aclk, aresetn, 1'b1, amt_now_reg <= AMOUNT_ONE)
    `ASSERT_NEXT(a_pos_wrap, aclk, aresetn, state_reg == ST_PLAY && act_len_reg != '0, LW'(pos_reg) < act_len_reg)

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the freeze looper with capture and crossfade.
// Depends on fflc_pkg and the freeze_loop_capture_crossfade RTL; a built-in
// predictor works out each mixed output item and a checker compares field by field.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fflc_pkg::*;

    localparam int  DEPTH        = 65536;
    localparam int  FADE_LIMIT   = 4096;
    localparam int  ONE          = 65536;
    localparam int  SETTLE       = 200;     // cycles after the last result
    localparam int  STALL_LIMIT  = 300000;  // full-depth capture plus divides
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // unmapped index

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    freeze_loop_capture_crossfade dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------- predictor state ----------------
    int hist_l [DEPTH];
    int hist_r [DEPTH];
    int loop_l [DEPTH];
    int loop_r [DEPTH];
    int unsigned wr_ptr, act_len, act_fade, play_pos;
    int unsigned amt_now, amt_prev, amt_goal, ramp_cnt;
    int ramp_inc;
    int unsigned len_reg, fade_reg, steps_reg;

    out_item_t expected_mix[$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;  // quiet stretch: neither side idles

    function automatic longint floor_quo(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    // nearest, ties toward +inf
    function automatic longint round_quo(longint n, longint d);
        return floor_quo(n + d / 2, d);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607) return 8388607;
        if (v < -64'sd8388608) return -8388608;
        return v;
    endfunction

    function automatic longint loop_sample(bit right, int unsigned pos);
        int unsigned k;
        longint here, head;
        here = right ? loop_r[pos] : loop_l[pos];
        if (act_fade > 0 && pos >= act_len - act_fade) begin
            k = pos - (act_len - act_fade);
            head = right ? loop_r[k] : loop_l[k];
            return round_quo(here * (act_fade - k) + head * k, act_fade);
        end
        return here;
    endfunction

    task automatic predictor_reset();
        for (int i = 0; i < DEPTH; i++) begin
            hist_l[i] = 0; hist_r[i] = 0; loop_l[i] = 0; loop_r[i] = 0;
        end
        wr_ptr = 0; act_len = 0; act_fade = 0; play_pos = 0;
        amt_now = 0; amt_prev = 0; amt_goal = 0; ramp_cnt = 0; ramp_inc = 0;
        len_reg = LOOP_LEN_RESET; fade_reg = XFADE_RESET; steps_reg = STEPS_RESET;
    endtask

    // copy the newest loop-length samples into the loop store
    task automatic grab_loop();
        int unsigned n, x, src;
        n = len_reg;
        x = fade_reg;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        if (x > FADE_LIMIT) x = FADE_LIMIT;
        if (x > n / 2) x = n / 2;
        act_len = n;
        act_fade = x;
        for (int unsigned i = 0; i < n; i++) begin
            src = (wr_ptr + DEPTH - n + i) % DEPTH;
            loop_l[i] = hist_l[src];
            loop_r[i] = hist_r[src];
        end
        play_pos = 0;
    endtask

    task automatic predict_mix(input in_item_t it, output out_item_t res);
        longint dry_l, dry_r, wet_l, wet_r, a, step, v;
        int unsigned tgt;
        dry_l = it.wet_left;
        dry_r = it.wet_right;
        wet_l = 0;
        wet_r = 0;
        hist_l[wr_ptr] = int'(dry_l);
        hist_r[wr_ptr] = int'(dry_r);
        wr_ptr = (wr_ptr + 1) % DEPTH;

        // new target
        tgt = it.freeze_target;
        if (tgt > ONE) tgt = ONE;
        if (tgt != amt_goal) begin
            if (steps_reg == 0) begin
                amt_goal = tgt; amt_now = tgt; ramp_cnt = 0; ramp_inc = 0;
            end else begin
                step = (longint'(tgt) - longint'(amt_now)) * 32768 / longint'(steps_reg);
                if (step > 64'sd2147483647) step = 2147483647;
                if (step < -64'sd2147483648) step = -2147483648;
                ramp_inc = int'(step);
                amt_goal = tgt;
                ramp_cnt = steps_reg;
            end
        end

        // ramp advance
        if (ramp_cnt != 0) begin
            ramp_cnt--;
            if (ramp_cnt == 0) begin
                amt_now = amt_goal;
            end else begin
                v = longint'(amt_goal) - round_quo(longint'(ramp_cnt) * ramp_inc, 32768);
                if (v < 0) v = 0;
                if (v > ONE) v = ONE;
                amt_now = int'(v);
            end
        end

        if (amt_prev == 0 && amt_now > 0) grab_loop();
        amt_prev = amt_now;

        if (act_len > 0) begin
            if (play_pos >= act_len) play_pos = act_fade;
            wet_l = loop_sample(1'b0, play_pos);
            wet_r = loop_sample(1'b1, play_pos);
            play_pos++;
            if (play_pos >= act_len) play_pos = act_fade;
        end

        a = amt_now;
        res.out_left  = clip24(round_quo(dry_l * (ONE - a) + wet_l * a, ONE));
        res.out_right = clip24(round_quo(dry_r * (ONE - a) + wet_r * a, ONE));
    endtask

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", m_data);
            end else begin
                want = expected_mix.pop_front();
                if (m_data.out_left !== want.out_left || m_data.out_right !== want.out_right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
                                 want.out_left, want.out_right,
                                 m_data.out_left, m_data.out_right);
                end
            end
        end
    end

    // receiver stalls: with a chance of about 22 percent, none in a quiet stretch
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 22);
    end

    // watchdog on cycles with no handshake on any channel
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- channel tasks ----------------
    task automatic send_item(input logic signed [23:0] l, input logic signed [23:0] r,
                             input logic [16:0] tgt);
        in_item_t it;
        out_item_t res;
        int gap;
        it.wet_left = l;
        it.wet_right = r;
        it.freeze_target = tgt;
        @(negedge aclk);
        if (!no_idle && $urandom_range(0, 99) < 22) begin
            gap = $urandom_range(1, 4);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mix(it, res);
        expected_mix.push_back(res);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // wait for all results, then let the block settle
    task automatic wait_idle();
        while (expected_mix.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_LOOP_LEN:   len_reg = val & 32'h1FFFF;
            REG_XFADE:      fade_reg = val & 32'h1FFF;
            REG_RAMP_STEPS: steps_reg = val & 32'hFFFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [16:0] rand_target();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) return 17'd0;
        if (pick < 5) return 17'd65536;
        if (pick < 6) return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(1, 65535));
    endfunction

    // ---------------- tests ----------------
    // reset values: default loop, fade, ramp; extremes of the samples
    task automatic test_reset_defaults();
        send_item(24'sh7FFFFF, -24'sh800000, 17'd0);
        send_item(-24'sh800000, 24'sh7FFFFF, 17'd0);
        send_item(24'sh000001, -24'sh000001, 17'd0);
        // above range saturates to full; rising edge captures 32768 samples
        send_item(24'sh7FFFFF, 24'sh7FFFFF, 17'h1FFFF);
        // same target must not restart the ramp
        send_item(-24'sh800000, -24'sh800000, 17'd65536);
        send_item(24'sh555555, -24'sh2AAAAA, 17'd65536);
        wait_idle();
    endtask

    // register extremes, unmapped index, jump ramp, full-depth capture
    task automatic test_register_extremes();
        write_reg(REG_RAMP_STEPS, 0);
        send_item(24'sh123456, 24'sh654321, 17'd0);        // jump back to zero
        wait_idle();
        write_reg(REG_LOOP_LEN, 65536);
        write_reg(REG_XFADE, 8191);                         // above fade limit
        write_reg(REG_NONE, 17'h1FFFF);                     // ignored
        send_item(-24'sh400000, 24'sh400000, 17'd65536);   // capture whole store
        send_item(24'sh7FFFFF, -24'sh800000, 17'd32768);
        send_item(24'sh000000, 24'sh000000, 17'd0);
        wait_idle();
        write_reg(REG_LOOP_LEN, 0);                         // clamps to one
        write_reg(REG_XFADE, 0);
        write_reg(REG_RAMP_STEPS, 1);                       // single-step ramp
        send_item(24'sh111111, -24'sh111111, 17'd1);
        send_item(24'sh222222, 24'sh333333, 17'd1);
        send_item(24'sh7FFFFF, 24'sh7FFFFF, 17'd0);
        wait_idle();
        write_reg(REG_LOOP_LEN, 5);
        write_reg(REG_XFADE, 4096);                         // limited to half loop
        write_reg(REG_RAMP_STEPS, 65535);
        for (int i = 0; i < 6; i++)
            send_item(24'($urandom), 24'($urandom), (i < 5) ? 17'd0 : 17'd65536);
        wait_idle();
    endtask

    // random phases; mostly small loops and short ramps so captures recur
    task automatic test_random_phases();
        int items;
        int burst;
        logic [16:0] tgt;
        items = 0;
        for (int ph = 0; items < 1500; ph++) begin
            wait_idle();
            no_idle = (ph % 5 == 2);
            write_reg(REG_LOOP_LEN, (ph % 17 == 9) ? $urandom_range(4096, 65536)
                                                   : $urandom_range(0, 300));
            write_reg(REG_XFADE, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                                             : $urandom_range(0, 150));
            write_reg(REG_RAMP_STEPS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 24));
            burst = $urandom_range(40, 120);
            tgt = rand_target();
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 99) < 8) tgt = rand_target();
                send_item(24'($urandom), 24'($urandom), tgt);
            end
            items += burst;
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    initial begin
        predictor_reset();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
